[hw/rtl/anagram_checker_assert.svh]
// Assertion macros shared by the anagram checker RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ANAGRAM_CHECKER_ASSERT_SVH
`define ANAGRAM_CHECKER_ASSERT_SVH

// same-cycle implication
`define ANC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ANC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/anc_pkg.sv]
// Types, constants and the case fold of the anagram checker.
// No dependencies.
package anc_pkg;

  localparam int unsigned SYM_W       = 8;
  localparam int unsigned NUM_SYM     = 256;
  localparam int unsigned UNB_W       = 9;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [SYM_W-1:0] FOLD_LOW  = 8'd96;
  localparam logic [SYM_W-1:0] FOLD_HIGH = 8'd127;
  localparam logic [SYM_W-1:0] FOLD_DROP = 8'd32;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             second;
    logic             last;
  } item_t;

  typedef struct packed {
    logic too_long;
    logic is_anagram;
  } result_t;

  function automatic logic [SYM_W-1:0] fold_sym(logic [SYM_W-1:0] b);
    logic [SYM_W-1:0] r;
    r = b;
    if (b >= FOLD_LOW && b <= FOLD_HIGH) begin
      r = b - FOLD_DROP;
    end
    return r;
  endfunction

endpackage

[hw/rtl/anagram_checker.sv]
// Top level of the case-insensitive anagram checker.
// Depends on anc_pkg, anc_front, anc_queue, anc_back, anc_ram.
//
//   channel   dir  handshake                        payload
//   s_axis    in   s_axis_tvalid / s_axis_tready    tdata symbol, tuser second_word,
//                                                   tlast pair_end
//   m_axis    out  m_axis_tvalid / m_axis_tready    tdata is_anagram, too_long
//
// One character beat per cycle sustained unless a result stalls; the histogram RAM
// is read as a beat enters the stage register and written back in the cycle after,
// with forwarding for repeated symbols. A pair-end beat passes queue and stage
// register into the result register, and per-bin valid flags clear the histogram
// as it lands. Reset is asynchronous; the queue absorbs stalls while a result waits.
module anagram_checker #(
  parameter int unsigned MAX_LEN = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic       s_axis_tuser,   // [0] second_word
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] is_anagram, [1] too_long, [7:2] zero
);
  import anc_pkg::*;

  logic    q_full, q_push, q_valid, q_pop;
  item_t   q_in, q_out;
  result_t res;

  anc_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_in)
  );

  anc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  anc_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_out),
    .item_pop_o   (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .result_o     (res)
  );

  assign m_axis_tdata = {6'b0, res.too_long, res.is_anagram};

endmodule

[hw/rtl/anc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module anc_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/anc_front.sv]
// Input side: takes character beats, folds case, forms queue entries.
// Depends on anc_pkg.
module anc_front (
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tlast,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output anc_pkg::item_t         q_item_o
);
  import anc_pkg::*;

  assign s_axis_tready   = !q_full_i;
  assign q_push_o        = s_axis_tvalid && !q_full_i;
  assign q_item_o.sym    = fold_sym(s_axis_tdata[SYM_W-1:0]);
  assign q_item_o.second = s_axis_tuser;
  assign q_item_o.last   = s_axis_tlast;

endmodule

[hw/rtl/anc_queue.sv]
// Short FIFO of folded characters between front and back.
// Depends on anc_pkg.
module anc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  anc_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output anc_pkg::item_t item_o
);
  import anc_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rptr_d = rptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[hw/rtl/anc_back.sv]
// Back end: histogram read-modify-write, length tracking, result register.
// Depends on anc_pkg, anc_ram and anagram_checker_assert.svh.
`include "anagram_checker_assert.svh"
module anc_back #(
  parameter int unsigned MAX_LEN = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  anc_pkg::item_t   item_i,
  output logic             item_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output anc_pkg::result_t result_o
);
  import anc_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_LEN + 2);
  localparam int unsigned BAL_W = $clog2(MAX_LEN + 1) + 1;
  localparam logic [LEN_W-1:0] LenMax = LEN_W'(MAX_LEN);
  localparam logic [LEN_W-1:0] LenSat = LEN_W'(MAX_LEN + 1);

  logic               s1_valid_q, s1_valid_d;
  item_t              s1_item_q;
  logic               fwd_hit_q, fwd_hit_d;
  logic [BAL_W-1:0]   fwd_data_q;
  logic [LEN_W-1:0]   first_len_q, first_len_d;
  logic [LEN_W-1:0]   second_len_q, second_len_d;
  logic               ovf_q, ovf_d;
  logic [UNB_W-1:0]   unb_q, unb_d;
  logic [NUM_SYM-1:0] bin_valid_q, bin_valid_d;
  logic               out_valid_q, out_valid_d;
  result_t            out_q;

  logic               s1_go, s1_ready, is_last;
  logic [LEN_W-1:0]   cur_len, new_len, first_new, second_new;
  logic               new_ovf, ram_we;
  logic [BAL_W-1:0]   rd_data, bal_old, after;
  logic [UNB_W-1:0]   unb_new;
  result_t            res;

  anc_ram #(
    .WIDTH (BAL_W),
    .DEPTH (NUM_SYM)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_item_q.sym),
    .wdata_i (after),
    .re_i    (item_pop_o),
    .raddr_i (item_i.sym),
    .rdata_o (rd_data)
  );

  assign is_last    = s1_item_q.last;
  assign s1_go      = s1_valid_q && !(is_last && out_valid_q && !out_ready_i);
  assign s1_ready   = !s1_valid_q || s1_go;
  assign item_pop_o = item_valid_i && s1_ready;

  always_comb begin
    cur_len = s1_item_q.second ? second_len_q : first_len_q;
    new_len = (cur_len < LenSat) ? cur_len + LEN_W'(1) : cur_len;
    new_ovf = ovf_q || (new_len > LenMax);
    first_new  = s1_item_q.second ? first_len_q : new_len;
    second_new = s1_item_q.second ? new_len : second_len_q;

    if (!bin_valid_q[s1_item_q.sym]) begin
      bal_old = '0;
    end else if (fwd_hit_q) begin
      bal_old = fwd_data_q;
    end else begin
      bal_old = rd_data;
    end
    after = s1_item_q.second ? bal_old - BAL_W'(1) : bal_old + BAL_W'(1);

    unb_new = unb_q;
    if (!new_ovf) begin
      if (bal_old == '0) begin
        unb_new = unb_q + UNB_W'(1);
      end else if (after == '0) begin
        unb_new = unb_q - UNB_W'(1);
      end
    end

    res.is_anagram = !new_ovf && (first_new == second_new) && (unb_new == '0);
    res.too_long   = new_ovf;
    ram_we         = s1_go && !new_ovf && !is_last;
  end

  always_comb begin
    first_len_d  = first_len_q;
    second_len_d = second_len_q;
    ovf_d        = ovf_q;
    unb_d        = unb_q;
    bin_valid_d  = bin_valid_q;
    if (s1_go) begin
      if (is_last) begin
        first_len_d  = '0;
        second_len_d = '0;
        ovf_d        = 1'b0;
        unb_d        = '0;
        bin_valid_d  = '0;
      end else begin
        first_len_d  = first_new;
        second_len_d = second_new;
        ovf_d        = new_ovf;
        unb_d        = unb_new;
        if (ram_we) begin
          bin_valid_d[s1_item_q.sym] = 1'b1;
        end
      end
    end

    s1_valid_d = s1_ready ? item_pop_o : s1_valid_q;
    fwd_hit_d  = item_pop_o ? (ram_we && (s1_item_q.sym == item_i.sym)) : fwd_hit_q;

    out_valid_d = out_valid_q;
    if (s1_go && is_last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      s1_item_q  <= item_i;
      fwd_data_q <= after;
    end
    if (s1_go && is_last) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      fwd_hit_q    <= 1'b0;
      first_len_q  <= '0;
      second_len_q <= '0;
      ovf_q        <= 1'b0;
      unb_q        <= '0;
      bin_valid_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      fwd_hit_q    <= fwd_hit_d;
      first_len_q  <= first_len_d;
      second_len_q <= second_len_d;
      ovf_q        <= ovf_d;
      unb_q        <= unb_d;
      bin_valid_q  <= bin_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  `ANC_ASSERT_NOW(a_no_result_overrun, s1_go && is_last,
                  !out_valid_q || out_ready_i, "result overwritten")
  `ANC_ASSERT_NXT(a_bins_cleared, s1_go && is_last, bin_valid_q == '0, "bins not cleared")
  `ANC_ASSERT_NOW(a_ovf_has_cause, ovf_q, (first_len_q > LenMax) || (second_len_q > LenMax),
                  "overflow without long word")

endmodule
